/* sv/rec_pkg.sv */
// ----------------------------------------------------------------------------
// Rotary encoder setting control package
// Shared widths, reset values, the quadrature lookup table, register indexes
// and the structs that pass between the encoder and the settings logic.
// ----------------------------------------------------------------------------
package rec_pkg;

  // Default values of the top-level parameters.
  localparam int WAVE_COUNT_DEF    = 8;
  localparam int DETENT_COUNTS_DEF = 4;

  // Field widths.
  localparam int TICK_W     = 32;
  localparam int FREQ_W     = 15;
  localparam int PRESS_W    = 16;
  localparam int WAVE_OUT_W = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int INC_W      = 7;

  // Register reset values.
  localparam logic [PRESS_W-1:0] PRESS_MIN_RESET = 16'd20;
  localparam logic [FREQ_W-1:0]  FLOOR_RESET     = 15'd1;
  localparam logic [FREQ_W-1:0]  CEIL_RESET      = 15'd20000;
  localparam logic [FREQ_W-1:0]  FREQ_RESET      = 15'd1000;

  // Frequency step size bands, chosen from the value before the step.
  localparam logic [FREQ_W-1:0] BAND_FINE   = 15'd100;
  localparam logic [FREQ_W-1:0] BAND_MID    = 15'd1000;
  localparam logic [FREQ_W-1:0] BAND_COARSE = 15'd5000;
  localparam logic [INC_W-1:0]  INC_FINE    = 7'd1;
  localparam logic [INC_W-1:0]  INC_MID     = 7'd10;
  localparam logic [INC_W-1:0]  INC_COARSE  = 7'd50;
  localparam logic [INC_W-1:0]  INC_MAX     = 7'd100;

  // Quadrature table, indexed by {previous AB, current AB}.
  localparam logic signed [1:0] QUAD_TABLE [0:15] = '{
    2'sd0,  -2'sd1,  2'sd1,  2'sd0,
    2'sd1,   2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
    2'sd0,   2'sd1, -2'sd1,  2'sd0
  };

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PRESS_MIN  = 2'd0,
    CFG_FREQ_FLOOR = 2'd1,
    CFG_FREQ_CEIL  = 2'd2
  } rec_cfg_addr_t;

  // Configuration register contents.
  typedef struct packed {
    logic [PRESS_W-1:0] press_min;
    logic [FREQ_W-1:0]  freq_floor;
    logic [FREQ_W-1:0]  freq_ceiling;
  } rec_cfg_t;

  // Detent step produced by the encoder logic for one poll.
  typedef struct packed {
    logic step;
    logic up;
  } rec_step_t;

endpackage

/* sv/rec_in_if.sv */
// ----------------------------------------------------------------------------
// Poll channel interface
// Carries one encoder and button poll with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rec_in_if;
  logic                       valid;
  logic                       ready;
  logic                       enc_a;
  logic                       enc_b;
  logic                       button_level;
  logic [rec_pkg::TICK_W-1:0] now_ticks;

  modport source (output valid, enc_a, enc_b, button_level, now_ticks, input ready);
  modport sink   (input valid, enc_a, enc_b, button_level, now_ticks, output ready);
endinterface

/* sv/rec_out_if.sv */
// ----------------------------------------------------------------------------
// Setting result channel interface
// Carries the settings after one poll with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rec_out_if;
  logic                           valid;
  logic                           ready;
  logic [rec_pkg::WAVE_OUT_W-1:0] waveform_index;
  logic [rec_pkg::FREQ_W-1:0]     freq_setting;
  logic                           edit_mode;
  logic                           settings_changed;

  modport source (output valid, waveform_index, freq_setting, edit_mode, settings_changed,
                  input ready);
  modport sink   (input valid, waveform_index, freq_setting, edit_mode, settings_changed,
                  output ready);
endinterface

/* sv/rec_quad.sv */
// ----------------------------------------------------------------------------
// Quadrature step decoder
// Looks up the AB transition, accumulates the counts and signals one detent
// step whenever the count reaches plus or minus the detent size.
// ----------------------------------------------------------------------------
module rec_quad #(
  parameter int DETENT_COUNTS = rec_pkg::DETENT_COUNTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic               enc_a,
  input  logic               enc_b,
  output rec_pkg::rec_step_t step
);

  localparam int ACC_W = $clog2(DETENT_COUNTS) + 2;
  localparam logic signed [ACC_W-1:0] DET_POS = ACC_W'(DETENT_COUNTS);
  localparam logic signed [ACC_W-1:0] DET_NEG = -DET_POS;

  logic [1:0]              prev_ab_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [1:0]       delta;
  logic [1:0]              cur_ab;

  // Transition lookup and running count.
  always_comb begin
    cur_ab  = {enc_a, enc_b};
    delta   = rec_pkg::QUAD_TABLE[{prev_ab_r, cur_ab}];
    acc_sum = acc_r + ACC_W'(delta);
    step.up   = (acc_sum >= DET_POS);
    step.step = step.up || (acc_sum <= DET_NEG);
    acc_nxt   = step.step ? '0 : acc_sum;
  end

  // Encoder state advances once per accepted poll.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ab_r <= 2'b11;
      acc_r     <= '0;
    end else if (advance) begin
      prev_ab_r <= cur_ab;
      acc_r     <= acc_nxt;
    end
  end

  // The stored count always lies strictly inside the detent window.
  a_acc_window: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r > DET_NEG) && (acc_r < DET_POS))
    else $error("step accumulator left the detent window");

endmodule

/* sv/rec_set.sv */
// ----------------------------------------------------------------------------
// Setting update logic
// Applies a detent step to the waveform index or the frequency, tracks the
// button press time and toggles the edit mode on a long enough press.
// ----------------------------------------------------------------------------
module rec_set #(
  parameter int WAVE_COUNT = rec_pkg::WAVE_COUNT_DEF,
  localparam int WSEL_W    = $clog2(WAVE_COUNT)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  rec_pkg::rec_step_t           step,
  input  logic                         button_level,
  input  logic [rec_pkg::TICK_W-1:0]   now_ticks,
  input  rec_pkg::rec_cfg_t            cfg,
  output logic [WSEL_W-1:0]            wave_nxt,
  output logic [rec_pkg::FREQ_W-1:0]   freq_nxt,
  output logic                         edit_nxt,
  output logic                         changed
);

  localparam logic [WSEL_W-1:0] WAVE_LAST = WSEL_W'(WAVE_COUNT - 1);
  localparam int SUM_W = rec_pkg::FREQ_W + 2;

  logic [WSEL_W-1:0]              wave_r;
  logic [rec_pkg::FREQ_W-1:0]     freq_r;
  logic                           edit_r;
  logic                           btn_prev_r;
  logic [rec_pkg::TICK_W-1:0]     press_time_r;
  logic [rec_pkg::TICK_W-1:0]     press_time_nxt;
  logic [rec_pkg::INC_W-1:0]      inc;
  logic signed [SUM_W-1:0]        freq_sum;
  logic signed [SUM_W-1:0]        floor_ext;
  logic signed [SUM_W-1:0]        ceil_ext;
  logic [rec_pkg::TICK_W-1:0]     elapsed;
  logic                           long_release;

  // Step size band from the frequency before the step.
  always_comb begin
    if (freq_r < rec_pkg::BAND_FINE) begin
      inc = rec_pkg::INC_FINE;
    end else if (freq_r < rec_pkg::BAND_MID) begin
      inc = rec_pkg::INC_MID;
    end else if (freq_r < rec_pkg::BAND_COARSE) begin
      inc = rec_pkg::INC_COARSE;
    end else begin
      inc = rec_pkg::INC_MAX;
    end
  end

  // Stepped frequency, checked against the floor first, then the ceiling.
  always_comb begin
    floor_ext = $signed({2'b00, cfg.freq_floor});
    ceil_ext  = $signed({2'b00, cfg.freq_ceiling});
    if (step.up) begin
      freq_sum = $signed({2'b00, freq_r}) + $signed(SUM_W'(inc));
    end else begin
      freq_sum = $signed({2'b00, freq_r}) - $signed(SUM_W'(inc));
    end
  end

  // Next settings; the mode used for the step is the one before the button.
  always_comb begin
    wave_nxt = wave_r;
    freq_nxt = freq_r;
    changed  = step.step;
    if (step.step && !edit_r) begin
      if (step.up) begin
        wave_nxt = (wave_r == WAVE_LAST) ? '0 : wave_r + 1'b1;
      end else begin
        wave_nxt = (wave_r == '0) ? WAVE_LAST : wave_r - 1'b1;
      end
    end else if (step.step) begin
      if (freq_sum < floor_ext) begin
        freq_nxt = cfg.freq_floor;
      end else if (freq_sum > ceil_ext) begin
        freq_nxt = cfg.freq_ceiling;
      end else begin
        freq_nxt = freq_sum[rec_pkg::FREQ_W-1:0];
      end
    end
  end

  // Button: a press records the time, a long enough release toggles the mode.
  always_comb begin
    elapsed        = now_ticks - press_time_r;
    long_release   = (elapsed > {{(rec_pkg::TICK_W-rec_pkg::PRESS_W){1'b0}}, cfg.press_min});
    press_time_nxt = press_time_r;
    edit_nxt       = edit_r;
    if (btn_prev_r && !button_level) begin
      press_time_nxt = now_ticks;
    end else if (!btn_prev_r && button_level && long_release) begin
      edit_nxt = !edit_r;
    end
  end

  // Setting state advances once per accepted poll.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r       <= '0;
      freq_r       <= rec_pkg::FREQ_RESET;
      edit_r       <= 1'b0;
      btn_prev_r   <= 1'b1;
      press_time_r <= '0;
    end else if (advance) begin
      wave_r       <= wave_nxt;
      freq_r       <= freq_nxt;
      edit_r       <= edit_nxt;
      btn_prev_r   <= button_level;
      press_time_r <= press_time_nxt;
    end
  end

  // A frequency step with a sane window lands inside that window.
  a_freq_window: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && step.step && edit_r && (cfg.freq_floor <= cfg.freq_ceiling))
    |=> (freq_r >= $past(cfg.freq_floor)) && (freq_r <= $past(cfg.freq_ceiling)))
    else $error("stepped frequency outside the floor and ceiling");

  // The waveform index never reaches the waveform count.
  a_wave_range: assert property (@(posedge clk) disable iff (!rst_n)
    wave_r <= WAVE_LAST)
    else $error("waveform index out of range");

endmodule

/* sv/rotary_encoder_setting_control.sv */
// ----------------------------------------------------------------------------
// Rotary encoder setting control
// Decodes encoder polls into waveform and frequency settings.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one poll per transfer: encoder pins A and B, the button
//   level and the tick time of the poll. out_ch returns one result per poll:
//   the waveform index, frequency, edit mode and a flag that a detent step
//   was taken, all as they stand after that poll.
//   cfg_we, cfg_addr and cfg_wdata write the press time, frequency floor and
//   frequency ceiling; write them only while no poll is in flight.
//   A poll's result is registered and shows in the cycle after the poll is
//   taken. One poll can be taken every cycle unless the receiver stalls;
//   all update logic sits between the setting state and one output register.
//   When the receiver stalls, the result holds and in_ch.ready drops until
//   the output register drains; a poll is taken in the same cycle the old
//   result leaves. Reset restores the register defaults, waveform 0,
//   1000 Hz, waveform mode, pins idle high and button released.
// ----------------------------------------------------------------------------
module rotary_encoder_setting_control #(
  parameter int WAVE_COUNT    = rec_pkg::WAVE_COUNT_DEF,
  parameter int DETENT_COUNTS = rec_pkg::DETENT_COUNTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rec_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rec_pkg::CFG_DATA_W-1:0] cfg_wdata,
  rec_in_if.sink                         in_ch,
  rec_out_if.source                      out_ch
);

  localparam int WSEL_W = $clog2(WAVE_COUNT);

  rec_pkg::rec_cfg_t           cfg_r;
  rec_pkg::rec_step_t          step;
  logic                        in_xfer;
  logic [WSEL_W-1:0]           wave_nxt;
  logic [WSEL_W+2:0]           wave_ext;
  logic [rec_pkg::FREQ_W-1:0]  freq_nxt;
  logic                        edit_nxt;
  logic                        changed;

  logic                              out_valid_r;
  logic [rec_pkg::WAVE_OUT_W-1:0]    out_wave_r;
  logic [rec_pkg::FREQ_W-1:0]        out_freq_r;
  logic                              out_edit_r;
  logic                              out_changed_r;

  // Take a poll whenever the output register is empty or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_min    <= rec_pkg::PRESS_MIN_RESET;
      cfg_r.freq_floor   <= rec_pkg::FLOOR_RESET;
      cfg_r.freq_ceiling <= rec_pkg::CEIL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rec_pkg::CFG_PRESS_MIN:  cfg_r.press_min    <= cfg_wdata;
        rec_pkg::CFG_FREQ_FLOOR: cfg_r.freq_floor   <= cfg_wdata[rec_pkg::FREQ_W-1:0];
        rec_pkg::CFG_FREQ_CEIL:  cfg_r.freq_ceiling <= cfg_wdata[rec_pkg::FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  rec_quad #(
    .DETENT_COUNTS (DETENT_COUNTS)
  ) u_quad (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_xfer),
    .enc_a   (in_ch.enc_a),
    .enc_b   (in_ch.enc_b),
    .step    (step)
  );

  rec_set #(
    .WAVE_COUNT (WAVE_COUNT)
  ) u_set (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (in_xfer),
    .step         (step),
    .button_level (in_ch.button_level),
    .now_ticks    (in_ch.now_ticks),
    .cfg          (cfg_r),
    .wave_nxt     (wave_nxt),
    .freq_nxt     (freq_nxt),
    .edit_nxt     (edit_nxt),
    .changed      (changed)
  );

  // The reported index is the low bits of the waveform selection.
  assign wave_ext = {3'b000, wave_nxt};

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_wave_r    <= wave_ext[rec_pkg::WAVE_OUT_W-1:0];
      out_freq_r    <= freq_nxt;
      out_edit_r    <= edit_nxt;
      out_changed_r <= changed;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.waveform_index   = out_wave_r;
  assign out_ch.freq_setting     = out_freq_r;
  assign out_ch.edit_mode        = out_edit_r;
  assign out_ch.settings_changed = out_changed_r;

  // A poll is never taken while a result is stuck in the output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_xfer && out_valid_r && !out_ch.ready))
    else $error("poll taken over an undelivered result");

  // Every accepted poll yields a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("accepted poll produced no result");

  // A stepped poll reports the step.
  a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && step.step) |=> out_changed_r)
    else $error("detent step not flagged");

endmodule
